[rtl/sxd_pkg.sv]
package sxd_pkg;

    localparam int DISPLAY_HEIGHT_DEF = 32;
    localparam int DISPLAY_WIDTH_DEF  = 64;

    localparam int SPRITE_W     = 8;
    localparam int X_POS_W      = 6;
    localparam int Y_BASE_W     = 5;
    localparam int ROW_INDEX_W  = 4;
    localparam int SCREEN_ROW_W = 5;

    // Enough conditional subtracts for the narrowest legal display.
    localparam int MOD_STEPS = 8;

    localparam logic ACT_DRAW  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [X_POS_W-1:0]     x_pos;
        logic [Y_BASE_W-1:0]    y_base;
        logic [ROW_INDEX_W-1:0] row_index;
        logic [SPRITE_W-1:0]    sprite_bits;
        logic                   first_row;
        logic                   last_row;
    } req_t;

    typedef struct packed {
        logic [SPRITE_W-1:0]     drawn_bits;
        logic [SCREEN_ROW_W-1:0] screen_row;
        logic                    collision;
        logic                    sprite_done;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_status_t;

    // Reduce a small value modulo a modulus by repeated compare and subtract.
    function automatic logic [7:0] mod_small(input logic [7:0] value,
                                             input logic [7:0] modulus);
        logic [7:0] r;
        r = value;
        for (int i = 0; i < MOD_STEPS; i++) begin
            if (r >= modulus) begin
                r = r - modulus;
            end
        end
        return r;
    endfunction

endpackage

[rtl/sxd_chan_if.sv]
interface sxd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/sxd_ctrl.sv]
module sxd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   rsp_ready,
    input  sxd_pkg::dp_status_t    sts,
    output sxd_pkg::ctrl_cmd_t     cmd
);
    import sxd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign req_ready   = (state_reg == ST_IDLE);
    assign cmd.capture = req_valid && req_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && (!sts.out_valid || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Stall in execute only while an untaken result blocks the output register.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && !cmd.commit) |-> sts.out_valid)
        else $error("execute stalled with empty output register");

    a_capture_enters_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("captured request did not enter execute");

    a_commit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (sts.out_valid && state_reg == ST_IDLE))
        else $error("commit did not load output register");

endmodule

[rtl/sxd_dp.sv]
module sxd_dp #(
    parameter int DISPLAY_HEIGHT = sxd_pkg::DISPLAY_HEIGHT_DEF,
    parameter int DISPLAY_WIDTH  = sxd_pkg::DISPLAY_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sxd_pkg::ctrl_cmd_t  cmd,
    output sxd_pkg::dp_status_t sts,
    input  sxd_pkg::req_t       req_item,
    output sxd_pkg::rsp_t       rsp_item,
    input  logic                rsp_ready
);
    import sxd_pkg::*;

    localparam int ROW_W = $clog2(DISPLAY_HEIGHT);
    localparam int COL_W = $clog2(DISPLAY_WIDTH);

    // Frame store: one word per display row, plus per-row valid bits so a
    // clear or reset takes effect at once.
    logic [DISPLAY_WIDTH-1:0] mem [DISPLAY_HEIGHT];
    logic [DISPLAY_HEIGHT-1:0] row_valid_reg;

    logic [DISPLAY_WIDTH-1:0] rd_data_reg;
    logic                     rd_vld_reg;
    req_t                     item_reg;
    logic [ROW_W-1:0]         row_reg;
    logic [COL_W-1:0]         x_reg;
    logic                     flag_reg;
    logic                     out_valid_reg;
    rsp_t                     rsp_reg;

    logic [ROW_W-1:0]         row_addr;
    logic [COL_W-1:0]         x_mod;
    logic [DISPLAY_WIDTH-1:0] old_row;
    logic [DISPLAY_WIDTH-1:0] flip_mask;
    logic [DISPLAY_WIDTH-1:0] new_row;
    logic [SPRITE_W-1:0]      drawn;
    logic                     hit;
    logic                     flag_next;

    assign row_addr = ROW_W'(mod_small(8'(req_item.y_base) + 8'(req_item.row_index),
                                       8'(DISPLAY_HEIGHT)));
    assign x_mod    = COL_W'(mod_small(8'(req_item.x_pos), 8'(DISPLAY_WIDTH)));

    always_comb
    begin
        logic [COL_W:0]   sum;
        logic [COL_W-1:0] col;
        logic             sbit;
        logic             obit;
        old_row   = rd_vld_reg ? rd_data_reg : '0;
        flip_mask = '0;
        drawn     = '0;
        hit       = 1'b0;
        for (int p = 0; p < SPRITE_W; p++)
        begin
            sum = {1'b0, x_reg} + (COL_W + 1)'(p);
            if (sum >= (COL_W + 1)'(DISPLAY_WIDTH))
            begin
                sum = sum - (COL_W + 1)'(DISPLAY_WIDTH);
            end
            col  = sum[COL_W-1:0];
            sbit = item_reg.sprite_bits[SPRITE_W-1-p];
            obit = old_row[col];
            drawn[SPRITE_W-1-p] = obit ^ sbit;
            hit  = hit | (obit & sbit);
            flip_mask[col] = sbit;
        end
        new_row   = old_row ^ flip_mask;
        flag_next = (item_reg.first_row ? 1'b0 : flag_reg) | hit;
    end

    // Address the store as the request is taken; on commit, write a drawn row back and load the result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= mem[row_addr];
            rd_vld_reg  <= row_valid_reg[row_addr];
            item_reg    <= req_item;
            row_reg     <= row_addr;
            x_reg       <= x_mod;
        end
        if (cmd.commit && item_reg.action == ACT_DRAW)
        begin
            mem[row_reg] <= new_row;
        end
        if (cmd.commit)
        begin
            if (item_reg.action == ACT_CLEAR)
            begin
                rsp_reg.drawn_bits  <= '0;
                rsp_reg.screen_row  <= '0;
                rsp_reg.collision   <= flag_reg;
                rsp_reg.sprite_done <= 1'b0;
            end
            else
            begin
                rsp_reg.drawn_bits  <= drawn;
                rsp_reg.screen_row  <= SCREEN_ROW_W'(row_reg);
                rsp_reg.collision   <= flag_next;
                rsp_reg.sprite_done <= item_reg.last_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (item_reg.action == ACT_CLEAR)
                begin
                    row_valid_reg <= '0;
                end
                else
                begin
                    row_valid_reg[row_reg] <= 1'b1;
                    flag_reg               <= flag_next;
                end
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_valid = out_valid_reg;
    assign rsp_item      = rsp_reg;

    a_clear_drops_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && item_reg.action == ACT_CLEAR) |=> (row_valid_reg == '0))
        else $error("clear left rows valid");

    a_clear_keeps_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && item_reg.action == ACT_CLEAR) |=> $stable(flag_reg))
        else $error("clear changed collision flag");

endmodule

[rtl/sprite_xor_draw_framebuffer_unit.sv]
// Channel  Dir  Payload  Handshake
// req      in   req_t    valid/ready, request taken when both high
// rsp      out  rsp_t    valid/ready, result taken when both high
//
// Each request is handled in order: the addressed frame-store row is read
// into a register as the request is taken; then the sprite row is XORed in,
// the row is written back and the output register is loaded.
// A clear request goes through the same steps; it drops all per-row valid bits at once.
// Reset (rst_n low, asynchronous) empties the store, the collision flag and
// the output register; no clearing pass follows.
// A result waiting in the output register does not block the next request;
// the write-back cycle holds only while that register is still full.
module sprite_xor_draw_framebuffer_unit #(
    parameter int DISPLAY_HEIGHT = sxd_pkg::DISPLAY_HEIGHT_DEF,
    parameter int DISPLAY_WIDTH  = sxd_pkg::DISPLAY_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    sxd_chan_if.sink   req,
    sxd_chan_if.source rsp
);
    import sxd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    req_t       req_item;
    rsp_t       rsp_item;

    // Control: two-state sequencer, decides when to capture and commit.
    sxd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    assign req_item = req.payload;

    // Datapath: frame store, read-modify-write, collision flag, output register.
    sxd_dp #(
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .DISPLAY_WIDTH  (DISPLAY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_item  (req_item),
        .rsp_item  (rsp_item),
        .rsp_ready (rsp.ready)
    );

    // Drive the result channel straight from the output register.
    assign rsp.valid   = sts.out_valid;
    assign rsp.payload = rsp_item;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import sxd_pkg::*;

    localparam int SCREEN_H      = DISPLAY_HEIGHT_DEF;
    localparam int SCREEN_W      = DISPLAY_WIDTH_DEF;
    localparam int REQ_W         = $bits(req_t);
    localparam int RANDOM_REQS   = 1500;
    localparam int MAX_GAP       = 19;
    // Long receiver hold-off: far longer than the block can buffer.
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT_A     = 300;
    localparam int HOLD_AT_B     = 900;
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        req_t req;
        bit   drain_first;  // hold this request until every result is back
    } queued_req_t;

    logic clk;
    logic rst_n;

    sxd_chan_if #(.payload_t(req_t)) req_ch ();
    sxd_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    sprite_xor_draw_framebuffer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow frame store: bit c of a row is screen column c.
    logic [SCREEN_W-1:0] shadow_screen [SCREEN_H];
    logic                shadow_collision;

    queued_req_t queued_draw_reqs [$];
    rsp_t        awaited_draw_results [$];

    int  mismatch_count;
    int  results_seen;
    int  cycle_count;
    int  src_idle_left;
    int  sink_stall_left;
    bit  src_burst;
    bit  sink_burst;

    // ------------------------------------------------------------------
    // Clock: 20 ns period.
    // ------------------------------------------------------------------
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model: apply one request to the shadow store and return the
    // result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic rsp_t xor_row_into_screen(req_t r);
        rsp_t res;
        int   row;
        int   col;
        logic pix_old;
        logic pix_spr;
        res = '0;
        // Clear: wipe every pixel, keep the collision flag, report row 0.
        if (r.action == ACT_CLEAR)
        begin
            foreach (shadow_screen[i])
                shadow_screen[i] = '0;
            res.collision = shadow_collision;
            return res;
        end
        // First row of a sprite starts a fresh collision check; without
        // the mark the flag keeps accumulating.
        if (r.first_row)
            shadow_collision = 1'b0;
        // Wrap vertically past the bottom edge.
        row = (int'(r.y_base) + int'(r.row_index)) % SCREEN_H;
        for (int p = 0; p < SPRITE_W; p++)
        begin
            // Wrap horizontally past the right edge; MSB is leftmost.
            col     = (int'(r.x_pos) % SCREEN_W + p) % SCREEN_W;
            pix_spr = r.sprite_bits[SPRITE_W-1-p];
            pix_old = shadow_screen[row][col];
            if (pix_spr && pix_old)
                shadow_collision = 1'b1;
            shadow_screen[row][col]        = pix_old ^ pix_spr;
            res.drawn_bits[SPRITE_W-1-p]   = pix_old ^ pix_spr;
        end
        res.screen_row  = row[SCREEN_ROW_W-1:0];
        res.collision   = shadow_collision;
        res.sprite_done = r.last_row;
        return res;
    endfunction

    function automatic req_t draw_req(int x, int y, int ri, int bits, bit first, bit last);
        req_t r;
        r.action      = ACT_DRAW;
        r.x_pos       = X_POS_W'(x);
        r.y_base      = Y_BASE_W'(y);
        r.row_index   = ROW_INDEX_W'(ri);
        r.sprite_bits = SPRITE_W'(bits);
        r.first_row   = first;
        r.last_row    = last;
        return r;
    endfunction

    // Clear request; the remaining fields are don't-care, so fill them with noise.
    function automatic req_t clear_req();
        req_t r;
        r        = req_t'(REQ_W'($urandom));
        r.action = ACT_CLEAR;
        return r;
    endfunction

    task automatic queue_req(req_t r, bit drain_first = 1'b0);
        queued_req_t q;
        q.req         = r;
        q.drain_first = drain_first;
        queued_draw_reqs.push_back(q);
    endtask

    // ------------------------------------------------------------------
    // Request driver: present queued requests one at a time with a random
    // gap before each, and hold a request on the bus until it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_reqs
        int gap_now;
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
            src_idle_left  <= 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            gap_now = src_idle_left;
            if (req_ch.valid)
            begin
                // Request taken: predict its result, then draw the next gap.
                awaited_draw_results.push_back(xor_row_into_screen(req_ch.payload));
                if ($urandom_range(0, 39) == 0)
                    src_burst = !src_burst;
                gap_now = src_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap_now > 0)
            begin
                req_ch.valid  <= 1'b0;
                src_idle_left <= gap_now - 1;
            end
            else if (queued_draw_reqs.size() != 0 &&
                     !(queued_draw_reqs[0].drain_first && awaited_draw_results.size() != 0))
            begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= queued_draw_reqs[0].req;
                void'(queued_draw_reqs.pop_front());
                src_idle_left  <= 0;
            end
            else
            begin
                // Nothing to send, or drain the block first.
                req_ch.valid  <= 1'b0;
                src_idle_left <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: take results with random stalls, check each against
    // the oldest prediction. Twice, hold ready low for a long stretch so
    // the block backs up and stalls its request side.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        int   stall_now;
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready    <= 1'b0;
            sink_stall_left <= 0;
        end
        else
        begin
            stall_now = sink_stall_left;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (awaited_draw_results.size() == 0)
                begin
                    $error("result with no request pending: %p", rsp_ch.payload);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_draw_results.pop_front();
                    if (rsp_ch.payload.drawn_bits !== want.drawn_bits)
                    begin
                        $error("drawn_bits: expected %02h, got %02h",
                               want.drawn_bits, rsp_ch.payload.drawn_bits);
                        mismatch_count++;
                    end
                    if (rsp_ch.payload.screen_row !== want.screen_row)
                    begin
                        $error("screen_row: expected %0d, got %0d",
                               want.screen_row, rsp_ch.payload.screen_row);
                        mismatch_count++;
                    end
                    if (rsp_ch.payload.collision !== want.collision)
                    begin
                        $error("collision: expected %b, got %b",
                               want.collision, rsp_ch.payload.collision);
                        mismatch_count++;
                    end
                    if (rsp_ch.payload.sprite_done !== want.sprite_done)
                    begin
                        $error("sprite_done: expected %b, got %b",
                               want.sprite_done, rsp_ch.payload.sprite_done);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    sink_burst = !sink_burst;
                stall_now = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
                    stall_now = LONG_HOLD;
            end
            if (stall_now > 0)
            begin
                rsp_ch.ready    <= 1'b0;
                sink_stall_left <= stall_now - 1;
            end
            else
            begin
                rsp_ch.ready    <= 1'b1;
                sink_stall_left <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if it hangs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sprite_xor_draw_framebuffer_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int sent;
        int pick;
        int rows;
        int ri0;
        int x;
        int y;
        int repeats;
        bit skip_first;
        bit drop_last;
        int sprite [16];

        // Drive every input to a known value from time zero.
        clk              = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.payload   = '0;
        rsp_ch.ready     = 1'b0;
        mismatch_count   = 0;
        results_seen     = 0;
        cycle_count      = 0;
        src_burst        = 1'b0;
        sink_burst       = 1'b0;
        shadow_collision = 1'b0;
        foreach (shadow_screen[i])
            shadow_screen[i] = '0;

        // Directed part.
        // Full row at the origin, then draw it again: erase and collide.
        queue_req(draw_req(0, 0, 0, 8'hFF, 1'b1, 1'b1));
        queue_req(draw_req(0, 0, 0, 8'hFF, 1'b1, 1'b1));
        // Bottom-right corner with the largest row index: both wraps at once.
        queue_req(draw_req(63, 31, 15, 8'h81, 1'b1, 1'b1));
        // Horizontal wrap of a full row from the last column.
        queue_req(draw_req(63, 0, 0, 8'hFF, 1'b1, 1'b1));
        // Only the rightmost sprite pixel wraps to column 0.
        queue_req(draw_req(57, 3, 0, 8'h01, 1'b1, 1'b1));
        // Vertical wrap edges: row 31 and row 0 from the bottom.
        queue_req(draw_req(10, 16, 15, 8'h3C, 1'b1, 1'b1));
        queue_req(draw_req(10, 31, 1, 8'hC3, 1'b1, 1'b1));
        // Multi-row sprite; its last row collides with its first.
        queue_req(draw_req(60, 5, 0, 8'hAA, 1'b1, 1'b0));
        queue_req(draw_req(60, 5, 1, 8'h55, 1'b0, 1'b0));
        queue_req(draw_req(60, 5, 0, 8'h80, 1'b0, 1'b1));
        // Clear keeps the collision flag; its other fields are ignored.
        queue_req(clear_req());
        // No first-row mark: flag carries over the clear.
        queue_req(draw_req(60, 5, 0, 8'h80, 1'b0, 1'b1));
        // Empty sprite row with first mark drops the flag.
        queue_req(draw_req(31, 15, 7, 8'h00, 1'b1, 1'b0));
        // Pause until the block is empty, then clear with zero fields.
        queue_req(req_t'({ACT_CLEAR, {(X_POS_W + Y_BASE_W + ROW_INDEX_W +
                                       SPRITE_W + 2){1'b0}}}), 1'b1);
        queue_req(draw_req(32, 8, 8, 8'h5A, 1'b1, 1'b1));
        queue_req(draw_req(33, 8, 8, 8'hA5, 1'b0, 1'b1));
        queue_req(clear_req());

        // Random part: mostly whole sprites (often drawn twice, as games
        // erase them), plus noise requests and broken sprites.
        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                queue_req(clear_req());
                sent++;
            end
            else if (pick < 15)
            begin
                req_t r;
                r = req_t'(REQ_W'($urandom));
                r.action = ACT_DRAW;
                queue_req(r);
                sent++;
            end
            else
            begin
                ri0        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                rows       = $urandom_range(1, 16 - ri0);
                x          = $urandom_range(0, SCREEN_W - 1);
                y          = $urandom_range(0, SCREEN_H - 1);
                skip_first = ($urandom_range(0, 9) == 0);
                drop_last  = ($urandom_range(0, 9) == 0);
                repeats    = ($urandom_range(0, 9) < 3) ? 2 : 1;
                for (int k = 0; k < rows; k++)
                    sprite[k] = $urandom_range(0, 255);
                for (int n = 0; n < repeats; n++)
                begin
                    for (int k = 0; k < rows; k++)
                    begin
                        queue_req(draw_req(x, y, ri0 + k, sprite[k],
                                           (k == 0) && !skip_first,
                                           (k == rows - 1) && !drop_last),
                                  (k == 0) && ($urandom_range(0, 199) == 0));
                        sent++;
                    end
                end
            end
        end

        // Release reset; the driver starts from here.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all requests to go out and all results to return.
        while (queued_draw_reqs.size() != 0 || req_ch.valid ||
               awaited_draw_results.size() != 0)
            @(posedge clk);
        // Watch a little longer for stray results.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && awaited_draw_results.size() == 0)
            $display("sprite_xor_draw_framebuffer_unit: match");
        else
            $display("sprite_xor_draw_framebuffer_unit: mismatch");
        $finish;
    end

endmodule

[files.f]
rtl/sxd_pkg.sv
rtl/sxd_chan_if.sv
rtl/sxd_ctrl.sv
rtl/sxd_dp.sv
rtl/sprite_xor_draw_framebuffer_unit.sv
tb/sv/tb_top.sv
